[hw/rtl/gte_pkg.sv]
// Graph traversal engine package: shared constants, payload types,
// controller states and the command/status structs between ctrl and datapath.
// No dependencies.
package gte_pkg;

  localparam int MaxNodes     = 64;
  localparam int MaxHalfEdges = 256;
  localparam int NodeW        = 6;
  localparam int CountW       = 7;
  localparam int AddrW        = 3;
  localparam int DataW        = 32;

  localparam logic [AddrW-1:0] RegNodeCountAddr = 3'd0;
  localparam logic [CountW-1:0] NodeCountReset  = 7'd64;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_BFS   = 2'd1,
    ACT_DFS   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_NODE    = 2'd0,
    ST_OK      = 2'd1,
    ST_REJECT  = 2'd2,
    ST_BAD_SRC = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [NodeW-1:0] visited_node;
    logic [1:0]       status;
    logic             last;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ADD1_RD,
    S_ADD1_WR,
    S_ADD2_RD,
    S_ADD2_WR,
    S_EMIT_OK,
    S_EMIT_REJ,
    S_EMIT_BAD,
    S_BFS_POP,
    S_BFS_LOAD,
    S_BFS_EMIT,
    S_BFS_EDGE,
    S_BFS_VISIT,
    S_DFS_INIT,
    S_DFS_TOP,
    S_DFS_POS,
    S_DFS_EDGE,
    S_DFS_VISIT,
    S_DFS_PUSH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    take_in;
    logic    trav_init;
    logic    add_entry;
    logic    add_link;
    logic    add_second;
    logic    clear_graph;
    logic    emit_status;
    status_e status;
    logic    fifo_pop;
    logic    load_cur;
    logic    shift_pend;
    logic    e_from_head;
    logic    edge_read;
    logic    bfs_visit;
    logic    dfs_init_pos;
    logic    pos_read;
    logic    e_from_pos;
    logic    sp_pop;
    logic    dfs_visit;
    logic    dfs_push;
    logic    emit_final;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       add_ok;
    logic       src_ok;
    logic       fifo_empty;
    logic       e_null;
    logic       nb_ok;
    logic       sp_zero;
    logic       out_free;
    logic       pend_vld;
  } stat_t;

endpackage

[hw/rtl/gte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/gte_ctrl.sv]
// Controller state machine for the graph traversal engine.
// Depends on gte_pkg; drives cmd_t to gte_dp and reads its stat_t.
module gte_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gte_pkg::stat_t  stat_i,
  output gte_pkg::cmd_t   cmd_o
);

  gte_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gte_pkg::S_IDLE: begin
        if (in_valid_i) state_d = gte_pkg::S_DECODE;
      end
      gte_pkg::S_DECODE: begin
        case (gte_pkg::action_e'(stat_i.act))
          gte_pkg::ACT_ADD:   state_d = stat_i.add_ok ? gte_pkg::S_ADD1_RD
                                                      : gte_pkg::S_EMIT_REJ;
          gte_pkg::ACT_CLEAR: state_d = gte_pkg::S_EMIT_OK;
          gte_pkg::ACT_BFS:   state_d = stat_i.src_ok ? gte_pkg::S_BFS_POP
                                                      : gte_pkg::S_EMIT_BAD;
          gte_pkg::ACT_DFS:   state_d = stat_i.src_ok ? gte_pkg::S_DFS_INIT
                                                      : gte_pkg::S_EMIT_BAD;
          default:            state_d = gte_pkg::S_IDLE;
        endcase
      end
      gte_pkg::S_ADD1_RD: state_d = gte_pkg::S_ADD1_WR;
      gte_pkg::S_ADD1_WR: state_d = gte_pkg::S_ADD2_RD;
      gte_pkg::S_ADD2_RD: state_d = gte_pkg::S_ADD2_WR;
      gte_pkg::S_ADD2_WR: state_d = gte_pkg::S_EMIT_OK;
      gte_pkg::S_EMIT_OK, gte_pkg::S_EMIT_REJ, gte_pkg::S_EMIT_BAD,
      gte_pkg::S_FINISH: begin
        if (stat_i.out_free) state_d = gte_pkg::S_IDLE;
      end
      gte_pkg::S_BFS_POP: begin
        state_d = stat_i.fifo_empty ? gte_pkg::S_FINISH : gte_pkg::S_BFS_LOAD;
      end
      gte_pkg::S_BFS_LOAD: state_d = gte_pkg::S_BFS_EMIT;
      gte_pkg::S_BFS_EMIT: begin
        if (stat_i.out_free || !stat_i.pend_vld) state_d = gte_pkg::S_BFS_EDGE;
      end
      gte_pkg::S_BFS_EDGE: begin
        state_d = stat_i.e_null ? gte_pkg::S_BFS_POP : gte_pkg::S_BFS_VISIT;
      end
      gte_pkg::S_BFS_VISIT: state_d = gte_pkg::S_BFS_EDGE;
      gte_pkg::S_DFS_INIT:  state_d = gte_pkg::S_DFS_TOP;
      gte_pkg::S_DFS_TOP: begin
        state_d = stat_i.sp_zero ? gte_pkg::S_FINISH : gte_pkg::S_DFS_POS;
      end
      gte_pkg::S_DFS_POS: state_d = gte_pkg::S_DFS_EDGE;
      gte_pkg::S_DFS_EDGE: begin
        state_d = stat_i.e_null ? gte_pkg::S_DFS_TOP : gte_pkg::S_DFS_VISIT;
      end
      gte_pkg::S_DFS_VISIT: begin
        state_d = stat_i.nb_ok ? gte_pkg::S_DFS_PUSH : gte_pkg::S_DFS_TOP;
      end
      gte_pkg::S_DFS_PUSH: begin
        if (stat_i.out_free) state_d = gte_pkg::S_DFS_TOP;
      end
      default: state_d = gte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.status = gte_pkg::ST_OK;
    case (state_q)
      gte_pkg::S_IDLE: cmd_o.take_in = in_valid_i;
      gte_pkg::S_DECODE: begin
        cmd_o.clear_graph = (gte_pkg::action_e'(stat_i.act) == gte_pkg::ACT_CLEAR);
        cmd_o.trav_init   = stat_i.src_ok &&
                            (gte_pkg::action_e'(stat_i.act) == gte_pkg::ACT_BFS ||
                             gte_pkg::action_e'(stat_i.act) == gte_pkg::ACT_DFS);
      end
      gte_pkg::S_ADD1_RD: cmd_o.add_entry = 1'b1;
      gte_pkg::S_ADD1_WR: cmd_o.add_link = 1'b1;
      gte_pkg::S_ADD2_RD: begin
        cmd_o.add_entry  = 1'b1;
        cmd_o.add_second = 1'b1;
      end
      gte_pkg::S_ADD2_WR: begin
        cmd_o.add_link   = 1'b1;
        cmd_o.add_second = 1'b1;
      end
      gte_pkg::S_EMIT_OK: begin
        cmd_o.emit_status = stat_i.out_free;
        cmd_o.status      = gte_pkg::ST_OK;
      end
      gte_pkg::S_EMIT_REJ: begin
        cmd_o.emit_status = stat_i.out_free;
        cmd_o.status      = gte_pkg::ST_REJECT;
      end
      gte_pkg::S_EMIT_BAD: begin
        cmd_o.emit_status = stat_i.out_free;
        cmd_o.status      = gte_pkg::ST_BAD_SRC;
      end
      gte_pkg::S_BFS_POP:  cmd_o.fifo_pop = !stat_i.fifo_empty;
      gte_pkg::S_BFS_LOAD: cmd_o.load_cur = 1'b1;
      gte_pkg::S_BFS_EMIT: begin
        cmd_o.shift_pend  = stat_i.out_free || !stat_i.pend_vld;
        cmd_o.e_from_head = stat_i.out_free || !stat_i.pend_vld;
      end
      gte_pkg::S_BFS_EDGE:  cmd_o.edge_read = !stat_i.e_null;
      gte_pkg::S_BFS_VISIT: cmd_o.bfs_visit = 1'b1;
      gte_pkg::S_DFS_INIT:  cmd_o.dfs_init_pos = 1'b1;
      gte_pkg::S_DFS_TOP:   cmd_o.pos_read = !stat_i.sp_zero;
      gte_pkg::S_DFS_POS:   cmd_o.e_from_pos = 1'b1;
      gte_pkg::S_DFS_EDGE: begin
        cmd_o.sp_pop    = stat_i.e_null;
        cmd_o.edge_read = !stat_i.e_null;
      end
      gte_pkg::S_DFS_VISIT: cmd_o.dfs_visit = 1'b1;
      gte_pkg::S_DFS_PUSH: begin
        cmd_o.shift_pend = stat_i.out_free;
        cmd_o.dfs_push   = stat_i.out_free;
      end
      gte_pkg::S_FINISH: cmd_o.emit_final = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != gte_pkg::S_IDLE);

endmodule

[hw/rtl/gte_dp.sv]
// Datapath of the graph traversal engine: edge store, list heads and tails,
// visited map, work FIFO/stack and output register. Depends on gte_pkg, gte_ram.
module gte_dp #(
  parameter int MAX_NODES      = gte_pkg::MaxNodes,
  parameter int MAX_HALF_EDGES = gte_pkg::MaxHalfEdges
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gte_pkg::in_t               in_data_i,
  input  logic [gte_pkg::CountW-1:0] lim_i,
  input  gte_pkg::cmd_t              cmd_i,
  output gte_pkg::stat_t             stat_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output gte_pkg::out_t              out_data_o
);

  localparam int NIW = $clog2(MAX_NODES);
  localparam int HW  = $clog2(MAX_HALF_EDGES);
  localparam int LW  = $clog2(MAX_HALF_EDGES + 1);
  localparam int SW  = $clog2(MAX_NODES + 1);
  localparam logic [LW-1:0] NullLink = LW'(MAX_HALF_EDGES);
  localparam logic [SW-1:0] NodesTop = SW'(MAX_NODES);

  logic [1:0]                 act_q;
  logic [gte_pkg::NodeW-1:0]  a_q, b_q;
  logic [LW-1:0]              cnt_q, e_q;
  logic [SW-1:0]              rd_q, wr_q, sp_q;
  logic [NIW-1:0]             cur_q, pend_q;
  logic                       pend_vld_q;
  logic [MAX_NODES-1:0]       vis_q, head_vld_q;
  logic                       out_vld_q;
  gte_pkg::out_t              out_q;

  logic [gte_pkg::NodeW-1:0]  owner, target, nb;
  logic [NIW-1:0]             owner_idx, nb_idx;
  logic [LW:0]                cnt_plus2;
  logic [LW-1:0]              head_e;
  logic                       room, nb_ok, out_free;

  logic                       tgt_we, link_we, head_we, tail_we, work_we, pos_we;
  logic                       edge_re, head_re, tail_re, work_re, pos_re;
  logic [HW-1:0]              tgt_waddr, link_waddr, edge_raddr, head_wdata, tail_wdata;
  logic [HW-1:0]              head_rdata, tail_rdata;
  logic [LW-1:0]              link_wdata, link_rdata, pos_wdata, pos_rdata;
  logic [gte_pkg::NodeW-1:0]  tgt_rdata;
  logic [NIW-1:0]             head_waddr, head_raddr, tail_addr;
  logic [NIW-1:0]             work_waddr, work_raddr, work_wdata, work_rdata;
  logic [NIW-1:0]             pos_waddr, pos_raddr;

  assign owner     = cmd_i.add_second ? b_q : a_q;
  assign target    = cmd_i.add_second ? a_q : b_q;
  assign owner_idx = owner[NIW-1:0];
  assign nb        = tgt_rdata;
  assign nb_idx    = nb[NIW-1:0];
  assign cnt_plus2 = {1'b0, cnt_q} + (LW+1)'(2);
  assign head_e    = head_vld_q[cur_q] ? LW'(head_rdata) : NullLink;
  assign room      = (gte_pkg::action_e'(act_q) == gte_pkg::ACT_DFS) ? (sp_q < NodesTop)
                                                                     : (wr_q < NodesTop);
  assign nb_ok     = ({1'b0, nb} < lim_i) && !vis_q[nb_idx] && room;
  assign out_free  = !out_vld_q || !out_stall_i;

  always_comb begin
    stat_o            = '0;
    stat_o.act        = act_q;
    stat_o.add_ok     = ({1'b0, a_q} < lim_i) && ({1'b0, b_q} < lim_i) &&
                        (cnt_plus2 <= (LW+1)'(MAX_HALF_EDGES));
    stat_o.src_ok     = ({1'b0, a_q} < lim_i);
    stat_o.fifo_empty = (rd_q == wr_q);
    stat_o.e_null     = (e_q >= NullLink);
    stat_o.nb_ok      = nb_ok;
    stat_o.sp_zero    = (sp_q == '0);
    stat_o.out_free   = out_free;
    stat_o.pend_vld   = pend_vld_q;
  end

  // Memory port steering
  always_comb begin
    tgt_we     = cmd_i.add_entry;
    tgt_waddr  = cnt_q[HW-1:0];
    link_we    = cmd_i.add_entry || (cmd_i.add_link && head_vld_q[owner_idx]);
    link_waddr = cmd_i.add_entry ? cnt_q[HW-1:0] : tail_rdata;
    link_wdata = cmd_i.add_entry ? NullLink : cnt_q;
    edge_re    = cmd_i.edge_read;
    edge_raddr = e_q[HW-1:0];

    head_we    = cmd_i.add_link && !head_vld_q[owner_idx];
    head_waddr = owner_idx;
    head_wdata = cnt_q[HW-1:0];
    head_re    = cmd_i.trav_init || cmd_i.load_cur || (cmd_i.dfs_visit && nb_ok);
    head_raddr = cmd_i.trav_init ? a_q[NIW-1:0] :
                 cmd_i.load_cur  ? work_rdata : nb_idx;

    tail_re    = cmd_i.add_entry;
    tail_we    = cmd_i.add_link;
    tail_addr  = owner_idx;
    tail_wdata = cnt_q[HW-1:0];

    work_we    = cmd_i.trav_init || (cmd_i.bfs_visit && nb_ok);
    work_waddr = cmd_i.trav_init ? '0 : wr_q[NIW-1:0];
    work_wdata = cmd_i.trav_init ? a_q[NIW-1:0] : nb_idx;
    work_re    = cmd_i.fifo_pop;
    work_raddr = rd_q[NIW-1:0];

    pos_we     = cmd_i.dfs_init_pos || cmd_i.dfs_visit || cmd_i.dfs_push;
    pos_waddr  = cmd_i.dfs_init_pos ? '0 :
                 cmd_i.dfs_visit    ? NIW'(sp_q - SW'(1)) : sp_q[NIW-1:0];
    pos_wdata  = cmd_i.dfs_visit ? link_rdata : head_e;
    pos_re     = cmd_i.pos_read;
    pos_raddr  = NIW'(sp_q - SW'(1));
  end

  gte_ram #(.Width(gte_pkg::NodeW), .Depth(MAX_HALF_EDGES)) u_tgt_ram (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_waddr), .wdata_i(target),
    .re_i(edge_re), .raddr_i(edge_raddr), .rdata_o(tgt_rdata)
  );

  gte_ram #(.Width(LW), .Depth(MAX_HALF_EDGES)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .re_i(edge_re), .raddr_i(edge_raddr), .rdata_o(link_rdata)
  );

  gte_ram #(.Width(HW), .Depth(MAX_NODES)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  gte_ram #(.Width(HW), .Depth(MAX_NODES)) u_tail_ram (
    .clk_i, .we_i(tail_we), .waddr_i(tail_addr), .wdata_i(tail_wdata),
    .re_i(tail_re), .raddr_i(tail_addr), .rdata_o(tail_rdata)
  );

  gte_ram #(.Width(NIW), .Depth(MAX_NODES)) u_work_ram (
    .clk_i, .we_i(work_we), .waddr_i(work_waddr), .wdata_i(work_wdata),
    .re_i(work_re), .raddr_i(work_raddr), .rdata_o(work_rdata)
  );

  gte_ram #(.Width(LW), .Depth(MAX_NODES)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .re_i(pos_re), .raddr_i(pos_raddr), .rdata_o(pos_rdata)
  );

  // Input item latch and traversal bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      act_q <= in_data_i.action;
      a_q   <= in_data_i.node_a;
      b_q   <= in_data_i.node_b;
    end
    if (cmd_i.trav_init) begin
      cur_q  <= a_q[NIW-1:0];
      pend_q <= a_q[NIW-1:0];
    end else if (cmd_i.load_cur) begin
      cur_q <= work_rdata;
    end else if (cmd_i.dfs_visit && nb_ok) begin
      cur_q <= nb_idx;
    end
    if (cmd_i.shift_pend) begin
      pend_q <= cur_q;
    end
    if (cmd_i.e_from_head) begin
      e_q <= head_e;
    end else if (cmd_i.e_from_pos) begin
      e_q <= pos_rdata;
    end else if (cmd_i.bfs_visit) begin
      e_q <= link_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      head_vld_q <= '0;
      vis_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      sp_q       <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear_graph) begin
        cnt_q      <= '0;
        head_vld_q <= '0;
      end
      if (cmd_i.add_link) begin
        cnt_q                 <= cnt_q + LW'(1);
        head_vld_q[owner_idx] <= 1'b1;
      end
      if (cmd_i.trav_init) begin
        // Only the source starts out visited
        vis_q      <= {{(MAX_NODES-1){1'b0}}, 1'b1} << a_q[NIW-1:0];
        rd_q       <= '0;
        wr_q       <= SW'(1);
        pend_vld_q <= (gte_pkg::action_e'(act_q) == gte_pkg::ACT_DFS);
      end
      if (cmd_i.fifo_pop) begin
        rd_q <= rd_q + SW'(1);
      end
      if ((cmd_i.bfs_visit || cmd_i.dfs_visit) && nb_ok) begin
        vis_q[nb_idx] <= 1'b1;
      end
      if (cmd_i.bfs_visit && nb_ok) begin
        wr_q <= wr_q + SW'(1);
      end
      if (cmd_i.shift_pend) begin
        pend_vld_q <= 1'b1;
      end
      if (cmd_i.dfs_init_pos) begin
        sp_q <= SW'(1);
      end else if (cmd_i.sp_pop) begin
        sp_q <= sp_q - SW'(1);
      end else if (cmd_i.dfs_push) begin
        sp_q <= sp_q + SW'(1);
      end
    end
  end

  // Output register: load on emit, drop once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_status || cmd_i.emit_final ||
                 (cmd_i.shift_pend && pend_vld_q)) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      out_q.visited_node <= '0;
      out_q.status       <= cmd_i.status;
      out_q.last         <= 1'b1;
    end else if (cmd_i.emit_final || (cmd_i.shift_pend && pend_vld_q)) begin
      out_q.visited_node <= gte_pkg::NodeW'(pend_q);
      out_q.status       <= gte_pkg::ST_NODE;
      out_q.last         <= cmd_i.emit_final;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/graph_traversal_engine.sv]
// Graph traversal engine top level: configuration register, controller and
// datapath. Depends on gte_pkg, gte_ctrl, gte_dp (and gte_ram through gte_dp).
//
// Usage: one input item per transaction on in_valid_i/in_stall_o carries an
// action (add edge, breadth-first, depth-first, clear) and two node numbers.
// Results leave on out_valid_o/out_stall_i; the final result of an item has
// last set. Add, clear and rejections give one status result; a traversal
// gives one result per reached node in visit order.
// Items are handled one at a time: in_stall_o is high from acceptance until
// the last result is loaded into the output register. Each list memory has
// a single registered read port. While out_stall_i holds a result, the
// engine waits at its next emit. Reset empties all neighbor lists, clears
// the edge count and sets node_count to 64; the user must write node_count
// through the APB port only while idle, which the engine does not enforce.
module graph_traversal_engine #(
  parameter int MAX_NODES      = gte_pkg::MaxNodes,
  parameter int MAX_HALF_EDGES = gte_pkg::MaxHalfEdges
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gte_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gte_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gte_pkg::AddrW-1:0]   paddr,
  input  logic [gte_pkg::DataW-1:0]   pwdata,
  output logic [gte_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  logic [gte_pkg::CountW-1:0] node_count_q, lim;
  gte_pkg::cmd_t              cmd;
  gte_pkg::stat_t             stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= gte_pkg::NodeCountReset;
    end else if (psel && penable && pwrite && paddr == gte_pkg::RegNodeCountAddr) begin
      node_count_q <= pwdata[gte_pkg::CountW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == gte_pkg::RegNodeCountAddr) ?
                  gte_pkg::DataW'(node_count_q) : '0;
  assign lim    = (node_count_q > gte_pkg::CountW'(MAX_NODES)) ?
                  gte_pkg::CountW'(MAX_NODES) : node_count_q;

  gte_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  gte_dp #(
    .MAX_NODES      (MAX_NODES),
    .MAX_HALF_EDGES (MAX_HALF_EDGES)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .lim_i   (lim),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

[dv/gte_checker.sv]
// Checker for the graph traversal engine: tracks node_count and the graph,
// predicts the results of each input transaction and compares them in order.
// Depends on gte_pkg.
`timescale 1ns / 1ps
module gte_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  gte_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  gte_pkg::out_t out_data_i,
  input  logic          cfg_wr_i,
  input  logic [6:0]    cfg_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  localparam int NullLink = gte_pkg::MaxHalfEdges;

  logic [5:0]    edge_target [gte_pkg::MaxHalfEdges];
  int            edge_next   [gte_pkg::MaxHalfEdges];
  int            head_of     [gte_pkg::MaxNodes];
  int            tail_of     [gte_pkg::MaxNodes];
  int            edge_total;
  bit            seen        [gte_pkg::MaxNodes];
  logic [6:0]    node_limit;
  gte_pkg::out_t expected_q  [$];

  assign pending_o = expected_q.size();

  function automatic int active_nodes();
    return (node_limit > gte_pkg::MaxNodes) ? gte_pkg::MaxNodes : int'(node_limit);
  endfunction

  task automatic push_result(input logic [5:0] node, input gte_pkg::status_e st);
    gte_pkg::out_t r;
    r.visited_node = node;
    r.status       = st;
    r.last         = 1'b0;
    expected_q     = {expected_q, r};
  endtask

  task automatic link_half(input int owner, input int target);
    int e;
    e = edge_total;
    edge_target[e] = target[5:0];
    edge_next[e]   = NullLink;
    if (head_of[owner] == NullLink) head_of[owner] = e;
    else edge_next[tail_of[owner]] = e;
    tail_of[owner] = e;
    edge_total = e + 1;
  endtask

  task automatic clear_lists();
    for (int i = 0; i < gte_pkg::MaxNodes; i++) head_of[i] = NullLink;
    edge_total = 0;
  endtask

  task automatic walk_breadth(input int src, input int lim);
    int fifo [gte_pkg::MaxNodes];
    int rd, wr, node, e, nb;
    rd = 0; wr = 1;
    fifo[0] = src;
    seen[src] = 1;
    while (rd < wr) begin
      node = fifo[rd]; rd++;
      push_result(node[5:0], gte_pkg::ST_NODE);
      e = head_of[node];
      while (e < gte_pkg::MaxHalfEdges) begin
        nb = edge_target[e];
        if (nb < lim && !seen[nb] && wr < gte_pkg::MaxNodes) begin
          seen[nb] = 1;
          fifo[wr] = nb; wr++;
        end
        e = edge_next[e];
      end
    end
  endtask

  task automatic walk_depth(input int src, input int lim);
    int pos [gte_pkg::MaxNodes];
    int sp, e, nb;
    seen[src] = 1;
    push_result(src[5:0], gte_pkg::ST_NODE);
    pos[0] = head_of[src];
    sp = 1;
    while (sp > 0) begin
      e = pos[sp-1];
      if (e >= gte_pkg::MaxHalfEdges) begin
        sp--;
      end else begin
        pos[sp-1] = edge_next[e];
        nb = edge_target[e];
        if (nb < lim && !seen[nb] && sp < gte_pkg::MaxNodes) begin
          seen[nb] = 1;
          push_result(nb[5:0], gte_pkg::ST_NODE);
          pos[sp] = head_of[nb];
          sp++;
        end
      end
    end
  endtask

  task automatic predict_item(input gte_pkg::in_t it);
    int lim, a, b, base;
    lim  = active_nodes();
    a    = it.node_a;
    b    = it.node_b;
    base = expected_q.size();
    case (gte_pkg::action_e'(it.action))
      gte_pkg::ACT_ADD: begin
        if (a >= lim || b >= lim || edge_total + 2 > gte_pkg::MaxHalfEdges) begin
          push_result('0, gte_pkg::ST_REJECT);
        end else begin
          link_half(a, b);
          link_half(b, a);
          push_result('0, gte_pkg::ST_OK);
        end
      end
      gte_pkg::ACT_CLEAR: begin
        clear_lists();
        push_result('0, gte_pkg::ST_OK);
      end
      default: begin
        if (a >= lim) begin
          push_result('0, gte_pkg::ST_BAD_SRC);
        end else begin
          for (int i = 0; i < gte_pkg::MaxNodes; i++) seen[i] = 0;
          if (it.action == gte_pkg::ACT_BFS) walk_breadth(a, lim);
          else walk_depth(a, lim);
        end
      end
    endcase
    if (expected_q.size() > base) expected_q[$].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input gte_pkg::out_t got,
                                 input gte_pkg::out_t want);
    $display("[%0t] mismatch %s: got node %0d status %0d last %0b, want %0d %0d %0b",
             $realtime, what, got.visited_node, got.status, got.last,
             want.visited_node, want.status, want.last);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gte_pkg::out_t want;
    if (!rst_ni) begin
      clear_lists();
      node_limit   <= gte_pkg::NodeCountReset;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_i) node_limit <= cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          want = '0;
          report_mismatch("unexpected result", out_data_i, want);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i !== want) report_mismatch("field", out_data_i, want);
        end
      end
    end
  end
endmodule

[dv/tb.sv]
// Testbench top for the graph traversal engine: clock, reset, APB writes,
// bursty stimulus and the verdict. Depends on gte_pkg, gte_checker and the RTL.
`timescale 1ns / 1ps
module tb;

  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gte_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gte_pkg::out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [gte_pkg::AddrW-1:0] paddr = '0;
  logic [gte_pkg::DataW-1:0] pwdata = '0;
  logic [gte_pkg::DataW-1:0] prdata;
  logic pready;
  int   fail_count, pending, idle_cycles;
  bit   stall_hold;

  always #5 clk_i = ~clk_i;

  graph_traversal_engine uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gte_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_wr_i(psel && penable && pwrite && pready && paddr == gte_pkg::RegNodeCountAddr),
    .cfg_data_i(pwdata[6:0]),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall pattern: quiet stretches alternate with random stalls.
  always @(negedge clk_i) begin
    if (($urandom % 64) == 0) stall_hold <= ~stall_hold;
    out_stall <= stall_hold ? 1'b0 : ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // Drop valid and let everything drain before touching node_count.
  task automatic write_nodes(input logic [6:0] val);
    in_valid <= 1'b0;
    wait_drained();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= gte_pkg::RegNodeCountAddr;
    pwdata <= {25'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Hold the item until a transaction takes it, then drop valid or chain.
  task automatic send_item(input gte_pkg::action_e act, input logic [5:0] a,
                           input logic [5:0] b);
    in_data.action <= act;
    in_data.node_a <= a;
    in_data.node_b <= b;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic random_phase(input int count, input int span);
    int r;
    logic [5:0] a, b;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      a = (r % 5 == 0) ? 6'($urandom) : 6'($urandom_range(0, span - 1));
      b = (r % 7 == 0) ? 6'($urandom) : 6'($urandom_range(0, span - 1));
      if (r < 55) send_item(gte_pkg::ACT_ADD, a, b);
      else if (r < 75) send_item(gte_pkg::ACT_BFS, a, b);
      else if (r < 95) send_item(gte_pkg::ACT_DFS, a, b);
      else send_item(gte_pkg::ACT_CLEAR, a, b);
    end
  endtask

  initial begin
    stall_hold = 1'b0;
    idle_cycles = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: self-loop, extremes, bad source, rejection, clear.
    send_item(gte_pkg::ACT_BFS, 6'd0, 6'd0);
    send_item(gte_pkg::ACT_ADD, 6'd0, 6'd0);
    send_item(gte_pkg::ACT_ADD, 6'd0, 6'd63);
    send_item(gte_pkg::ACT_ADD, 6'd63, 6'd5);
    send_item(gte_pkg::ACT_ADD, 6'd5, 6'd1);
    send_item(gte_pkg::ACT_BFS, 6'd0, 6'd63);
    send_item(gte_pkg::ACT_DFS, 6'd63, 6'd0);
    send_item(gte_pkg::ACT_DFS, 6'd1, 6'd42);
    write_nodes(7'd6);
    send_item(gte_pkg::ACT_ADD, 6'd2, 6'd63);
    send_item(gte_pkg::ACT_BFS, 6'd0, 6'd0);
    send_item(gte_pkg::ACT_DFS, 6'd0, 6'd0);
    send_item(gte_pkg::ACT_BFS, 6'd6, 6'd0);
    write_nodes(7'd0);
    send_item(gte_pkg::ACT_ADD, 6'd0, 6'd0);
    send_item(gte_pkg::ACT_DFS, 6'd0, 6'd0);
    write_nodes(7'd127);
    send_item(gte_pkg::ACT_BFS, 6'd63, 6'd21);
    send_item(gte_pkg::ACT_CLEAR, 6'd0, 6'd0);
    send_item(gte_pkg::ACT_DFS, 6'd0, 6'd0);
    in_valid <= 1'b0;

    // Fill the edge store to its limit, then see the overflow rejected.
    write_nodes(7'd64);
    for (int i = 0; i < 129; i++)
      send_item(gte_pkg::ACT_ADD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    send_item(gte_pkg::ACT_BFS, 6'($urandom), 6'd0);
    send_item(gte_pkg::ACT_DFS, 6'($urandom), 6'd0);
    send_item(gte_pkg::ACT_CLEAR, 6'd0, 6'd0);
    in_valid <= 1'b0;

    write_nodes(7'd8);
    random_phase(12, 10);
    in_valid <= 1'b0;
    write_nodes(7'd1);
    random_phase(4, 2);
    in_valid <= 1'b0;
    write_nodes(7'd64);
    send_item(gte_pkg::ACT_CLEAR, 6'd0, 6'd0);
    random_phase(6, 64);
    in_valid <= 1'b0;
    write_nodes(7'd20);
    random_phase(6, 24);
    in_valid <= 1'b0;

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/gte_pkg.sv
hw/rtl/gte_ram.sv
hw/rtl/gte_ctrl.sv
hw/rtl/gte_dp.sv
hw/rtl/graph_traversal_engine.sv
dv/gte_checker.sv
dv/tb.sv
